>>> rtl/cbd_pkg.sv
// Package for the chunked body decoder: shared types, codes and constants.
// Used by every module under rtl/; it depends on nothing else.
package cbd_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = 32'd16777216;

  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_EXT  = 3'd1,
    PH_SEP  = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_OVER  = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  // One input transfer as held in the input register.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } in_item_t;

  // Result of one step; has_res says whether a transfer leaves at all.
  typedef struct packed {
    logic              has_res;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              final_res;
    status_e           status;
  } step_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_crlf(input logic [BYTE_W-1:0] c);
    return (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

>>> rtl/cbd_in_stage.sv
// Input register of the chunked body decoder (depends on cbd_pkg): takes one
// byte per cycle unless stalled, holding it until the parser steps on it.
module cbd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cbd_pkg::in_item_t in_item_i,
  input  logic             step_en_i,
  output logic             item_valid_o,
  output cbd_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  cbd_pkg::in_item_t item_q;

  // The register frees up in the same cycle that the parser consumes it.
  assign in_ready_o = !valid_q || step_en_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/cbd_parser.sv
// Chunk parser: phase, size and remaining-count registers with the per-byte
// next-state and result logic, plus the size limit register. Uses cbd_pkg.
module cbd_parser #(
  parameter int unsigned COUNT_WIDTH = cbd_pkg::COUNT_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cbd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       step_en_i,
  input  cbd_pkg::in_item_t          item_i,
  output cbd_pkg::step_res_t         res_o
);

  localparam int unsigned LW = (COUNT_WIDTH > cbd_pkg::CFG_W) ? COUNT_WIDTH : cbd_pkg::CFG_W;

  logic [cbd_pkg::CFG_W-1:0] max_q;
  cbd_pkg::phase_e           phase_q, phase_d, phase_step;
  logic [COUNT_WIDTH-1:0]    size_q, size_d, size_step;
  logic [COUNT_WIDTH-1:0]    left_q, left_d, left_step;

  logic [LW-1:0]             cfg_ext, cmask_ext, lim;
  logic [COUNT_WIDTH-1:0]    sv_in, sz_value, size_dec, left_dec;
  cbd_pkg::phase_e           sz_phase;
  cbd_pkg::hex_t             hex;
  logic                      crlf, semi;

  assign crlf = cbd_pkg::is_crlf(item_i.data);
  assign semi = (item_i.data == cbd_pkg::CHAR_SEMI);
  assign hex  = cbd_pkg::hex_decode(item_i.data);

  // The limit is the smaller of the register and what the counters can hold.
  assign cfg_ext   = LW'(max_q);
  assign cmask_ext = LW'({COUNT_WIDTH{1'b1}});
  assign lim       = (cfg_ext > cmask_ext) ? cmask_ext : cfg_ext;

  // A size field restarts from zero when it follows a chunk's data.
  assign sv_in = (phase_q == cbd_pkg::PH_TAIL) ? '0 : size_q;

  // One byte of a size field. Growing value v by digit h stays within lim
  // exactly when h <= lim and v <= (lim - h) / 16.
  always_comb begin
    sz_phase = cbd_pkg::PH_SIZE;
    sz_value = sv_in;
    if (crlf || semi) begin
      if (sv_in == '0) begin
        sz_phase = cbd_pkg::PH_DONE;
      end else if (semi) begin
        sz_phase = cbd_pkg::PH_EXT;
      end else begin
        sz_phase = cbd_pkg::PH_SEP;
      end
    end else if (!hex.ok || (LW'(hex.val) > lim) ||
                 (LW'(sv_in) > ((lim - LW'(hex.val)) >> 4))) begin
      sz_phase = cbd_pkg::PH_ERR;
    end else begin
      sz_value = {sv_in[COUNT_WIDTH-5:0], hex.val};
    end
  end

  assign size_dec = size_q - COUNT_WIDTH'(1);
  assign left_dec = left_q - COUNT_WIDTH'(1);

  // Next state for the byte in the input register.
  always_comb begin
    phase_step = phase_q;
    size_step  = size_q;
    left_step  = left_q;
    unique case (phase_q)
      cbd_pkg::PH_SIZE: begin
        phase_step = sz_phase;
        size_step  = sz_value;
      end
      cbd_pkg::PH_EXT: begin
        if (crlf) begin
          phase_step = cbd_pkg::PH_SEP;
        end
      end
      cbd_pkg::PH_SEP: begin
        if (!crlf) begin
          left_step  = size_dec;
          phase_step = (size_dec == '0) ? cbd_pkg::PH_TAIL : cbd_pkg::PH_DATA;
        end
      end
      cbd_pkg::PH_DATA: begin
        left_step = left_dec;
        if (left_dec == '0) begin
          phase_step = cbd_pkg::PH_TAIL;
        end
      end
      cbd_pkg::PH_TAIL: begin
        if (!crlf) begin
          phase_step = sz_phase;
          size_step  = sz_value;
        end
      end
      cbd_pkg::PH_DONE, cbd_pkg::PH_ERR: begin
        phase_step = phase_q;
      end
      default: begin
        phase_step = cbd_pkg::PH_ERR;
      end
    endcase

    // The last byte of a body leaves the parser ready for the next body.
    if (item_i.last) begin
      phase_d = cbd_pkg::PH_SIZE;
      size_d  = '0;
      left_d  = '0;
    end else begin
      phase_d = phase_step;
      size_d  = size_step;
      left_d  = left_step;
    end
  end

  // Result for the byte in the input register.
  always_comb begin
    res_o            = '0;
    res_o.byte_valid = ((phase_q == cbd_pkg::PH_SEP) && !crlf) ||
                       (phase_q == cbd_pkg::PH_DATA);
    res_o.out_byte   = res_o.byte_valid ? item_i.data : '0;
    res_o.final_res  = item_i.last;
    res_o.has_res    = res_o.byte_valid || item_i.last;
    res_o.status     = cbd_pkg::ST_OK;
    if (item_i.last) begin
      unique case (phase_step)
        cbd_pkg::PH_DONE: res_o.status = cbd_pkg::ST_OK;
        cbd_pkg::PH_ERR:  res_o.status = cbd_pkg::ST_BAD;
        cbd_pkg::PH_SIZE: res_o.status = (size_step == '0) ? cbd_pkg::ST_OK
                                                            : cbd_pkg::ST_OVER;
        cbd_pkg::PH_TAIL: res_o.status = cbd_pkg::ST_TRUNC;
        default:          res_o.status = cbd_pkg::ST_OVER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= cbd_pkg::MAX_CHUNK_RESET;
      phase_q <= cbd_pkg::PH_SIZE;
      size_q  <= '0;
      left_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (step_en_i) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        left_q  <= left_d;
      end
    end
  end

endmodule

>>> rtl/chunked_body_decoder.sv
// Top level of the chunked body decoder: input register, chunk parser and
// the output register. Depends on cbd_pkg, cbd_in_stage and cbd_parser.
//
//   Channel   Direction  Signals                          Contents
//   s_axis    in         tvalid/tready/tdata/tlast        body byte, last-byte mark
//   m_axis    out        tvalid/tready/tdata/tuser/tlast  payload byte and status,
//                                                         byte flag, final
//   cfg       in         cfg_we_i/cfg_wdata_i             max_chunk_size
//
// One byte is accepted per clock while the output is not stalled; a byte's result
// can leave at the earliest once it has passed the input register and been parsed
// into the result register. Bytes that produce no result are dropped inside the block.
// A stalled output holds its result and backs up through the input register.
// Reset returns the parser to the start of a body and max_chunk_size to
// 16777216.
module chunked_body_decoder #(
  parameter int unsigned COUNT_WIDTH = cbd_pkg::COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cbd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [cbd_pkg::BYTE_W-1:0]      s_axis_tdata_i,   // [7:0] in_byte
  input  logic                            s_axis_tlast_i,   // last_byte
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [cbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] status
  output logic                            m_axis_tuser_o,   // byte_valid
  output logic                            m_axis_tlast_o    // final_res
);

  cbd_pkg::in_item_t  in_item, item;
  cbd_pkg::step_res_t res, out_q;
  logic               item_valid, step_en;
  logic               out_valid_q, out_valid_d;

  assign in_item.data = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  // The parser steps when a byte is held and the result register is free or being emptied.
  assign step_en = item_valid && (!out_valid_q || m_axis_tready_i);

  cbd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .step_en_i    (step_en),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cbd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_en_i   (step_en),
    .item_i      (item),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = res.has_res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && res.has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(cbd_pkg::OUT_TDATA_W - cbd_pkg::BYTE_W - cbd_pkg::STATUS_W){1'b0}},
                            out_q.status, out_q.out_byte};
  assign m_axis_tuser_o  = out_q.byte_valid;
  assign m_axis_tlast_o  = out_q.final_res;

endmodule

>>> tb/chunked_body_decoder_test.sv
// Self-checking testbench for chunked_body_decoder: directed bodies, then random
// bodies under several max_chunk_size settings. Depends on cbd_pkg and the RTL.
module chunked_body_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [63:0] CNT_MASK = 64'({cbd_pkg::COUNT_WIDTH{1'b1}});

  // One body byte, with an optional hand-written expectation.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    logic [7:0]       t_out;
    logic             t_valid;
    logic             t_final;
    cbd_pkg::status_e t_status;
  } body_row_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             final_res;
    cbd_pkg::status_e status;
  } decoded_t;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [cbd_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [cbd_pkg::BYTE_W-1:0]        s_tdata = '0;
  logic                              s_tlast = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [cbd_pkg::OUT_TDATA_W-1:0]   m_tdata;
  logic                              m_tuser;
  logic                              m_tlast;

  // Predictor state.
  cbd_pkg::phase_e chunk_phase = cbd_pkg::PH_SIZE;
  logic [63:0]     chunk_size = '0;
  logic [63:0]     chunk_left = '0;
  logic [31:0]     size_limit = cbd_pkg::MAX_CHUNK_RESET;

  body_row_t directed_rows [23];
  body_row_t body_q [$];
  body_row_t build_q [$];
  body_row_t cur_row;
  decoded_t  decoded_q [$];

  int errors = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int bodies_sent = 0;
  int send_gap_pct = 0;
  int ready_drop_pct = 0;

  chunked_body_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == cbd_pkg::CHAR_CR) || (c == cbd_pkg::CHAR_LF);
  endfunction

  function automatic int hex_digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic take_size_char(input logic [7:0] c);
    logic [63:0] lim;
    int          h;
    lim = {32'b0, size_limit};
    if (lim > CNT_MASK) lim = CNT_MASK;
    if (is_line_end(c) || c == cbd_pkg::CHAR_SEMI) begin
      if (chunk_size == 0) chunk_phase = cbd_pkg::PH_DONE;
      else chunk_phase = (c == cbd_pkg::CHAR_SEMI) ? cbd_pkg::PH_EXT : cbd_pkg::PH_SEP;
    end else begin
      h = hex_digit_val(c);
      if (h < 0 || 64'(h) > lim || chunk_size > (lim - 64'(h)) / 16) begin
        chunk_phase = cbd_pkg::PH_ERR;
      end else begin
        chunk_size = (chunk_size * 16 + 64'(h)) & CNT_MASK;
      end
    end
  endtask

  // Advances the predicted parser by one body byte.
  task automatic decode_body_byte(input logic [7:0] c, input logic last,
                                  output logic has, output decoded_t r);
    logic             valid;
    cbd_pkg::status_e st;
    valid = 1'b0;
    st = cbd_pkg::ST_OK;
    case (chunk_phase)
      cbd_pkg::PH_SIZE: take_size_char(c);
      cbd_pkg::PH_EXT: begin
        if (is_line_end(c)) chunk_phase = cbd_pkg::PH_SEP;
      end
      cbd_pkg::PH_SEP: begin
        if (!is_line_end(c)) begin
          valid = 1'b1;
          chunk_left = (chunk_size - 1) & CNT_MASK;
          chunk_phase = (chunk_left == 0) ? cbd_pkg::PH_TAIL : cbd_pkg::PH_DATA;
        end
      end
      cbd_pkg::PH_DATA: begin
        valid = 1'b1;
        chunk_left = (chunk_left - 1) & CNT_MASK;
        if (chunk_left == 0) chunk_phase = cbd_pkg::PH_TAIL;
      end
      cbd_pkg::PH_TAIL: begin
        if (!is_line_end(c)) begin
          chunk_size = '0;
          chunk_phase = cbd_pkg::PH_SIZE;
          take_size_char(c);
        end
      end
      cbd_pkg::PH_DONE: ;
      default: chunk_phase = cbd_pkg::PH_ERR;
    endcase
    if (last) begin
      case (chunk_phase)
        cbd_pkg::PH_DONE: st = cbd_pkg::ST_OK;
        cbd_pkg::PH_ERR:  st = cbd_pkg::ST_BAD;
        cbd_pkg::PH_SIZE: st = (chunk_size == 0) ? cbd_pkg::ST_OK : cbd_pkg::ST_OVER;
        cbd_pkg::PH_TAIL: st = cbd_pkg::ST_TRUNC;
        default:          st = cbd_pkg::ST_OVER;
      endcase
    end
    has = valid || last;
    r.out_byte = valid ? c : 8'h00;
    r.byte_valid = valid;
    r.final_res = last;
    r.status = st;
    if (last) begin
      chunk_phase = cbd_pkg::PH_SIZE;
      chunk_size = '0;
      chunk_left = '0;
    end
  endtask

  // Sender: predicts each transfer as it is accepted, then offers the next byte.
  always @(posedge clk_i) begin
    logic     has;
    decoded_t r;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        decode_body_byte(s_tdata, s_tlast, has, r);
        if (cur_row.typed) begin
          r = decoded_t'{cur_row.t_out, cur_row.t_valid, cur_row.t_final, cur_row.t_status};
          has = 1'b1;
        end
        if (has) decoded_q.push_back(r);
      end
      if (!s_tvalid || s_tready) begin
        if (body_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_row = body_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= cur_row.data;
          s_tlast <= cur_row.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_tready <= ($urandom_range(99) >= ready_drop_pct);
  end

  always @(posedge clk_i) begin
    decoded_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        $error("output transfer with nothing expected: tdata=%h tuser=%b tlast=%b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        results_checked++;
        if (m_tdata[cbd_pkg::BYTE_W-1:0] !== e.out_byte) begin
          $error("out_byte: expected %h, got %h", e.out_byte, m_tdata[cbd_pkg::BYTE_W-1:0]);
          errors++;
        end
        if (m_tuser !== e.byte_valid) begin
          $error("byte_valid: expected %b, got %b", e.byte_valid, m_tuser);
          errors++;
        end
        if (m_tlast !== e.final_res) begin
          $error("final_res: expected %b, got %b", e.final_res, m_tlast);
          errors++;
        end
        if (m_tdata[cbd_pkg::BYTE_W +: cbd_pkg::STATUS_W] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status,
                 m_tdata[cbd_pkg::BYTE_W +: cbd_pkg::STATUS_W]);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (body_q.size() > 0 || s_tvalid || decoded_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_chunk(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    size_limit = v;
  endtask

  task automatic push_raw(input logic [7:0] b);
    build_q.push_back(body_row_t'{b, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic emit_size(input logic [31:0] v);
    int k;
    repeat ($urandom_range(0, 2)) push_raw("0");
    for (k = 7; k > 0 && v[k*4 +: 4] == 0; k--) ;
    for (; k >= 0; k--) push_raw(hex_char(v[k*4 +: 4]));
  endtask

  task automatic emit_ext();
    logic [7:0] b;
    if ($urandom_range(3) == 0) begin
      push_raw(cbd_pkg::CHAR_SEMI);
      repeat ($urandom_range(0, 4)) begin
        do b = 8'($urandom); while (is_line_end(b));
        push_raw(b);
      end
    end
  endtask

  task automatic emit_line_ends();
    repeat ($urandom_range(1, 3))
      push_raw($urandom_range(1) ? cbd_pkg::CHAR_CR : cbd_pkg::CHAR_LF);
  endtask

  // Well-formed body: up to three chunks, the terminal chunk, maybe ignored trailing bytes.
  task automatic build_good_body(output int junk);
    logic [7:0]  b;
    logic [31:0] sz;
    repeat ($urandom_range(0, 3)) begin
      sz = $urandom_range(1, 20);
      if (sz > size_limit) sz = size_limit;
      emit_size(sz);
      emit_ext();
      emit_line_ends();
      do b = 8'($urandom); while (is_line_end(b));
      push_raw(b);
      repeat (sz - 1) push_raw(8'($urandom));
      emit_line_ends();
    end
    if ($urandom_range(4) != 0) repeat ($urandom_range(1, 2)) push_raw("0");
    emit_ext();
    emit_line_ends();
    junk = ($urandom_range(9) < 3) ? $urandom_range(1, 4) : 0;
    repeat (junk) push_raw(8'($urandom));
  endtask

  // Size field with random digits, possibly too large or broken by a stray byte.
  task automatic build_bad_size_body();
    int         n;
    int         bad_at;
    logic [7:0] b;
    n = $urandom_range(1, 10);
    bad_at = $urandom_range(1) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) begin
        do b = 8'($urandom);
        while (is_line_end(b) || b == cbd_pkg::CHAR_SEMI || hex_digit_val(b) >= 0);
        push_raw(b);
      end else begin
        push_raw(hex_char(4'($urandom_range(15))));
      end
    end
    repeat ($urandom_range(0, 6)) push_raw(8'($urandom));
  endtask

  task automatic queue_random_body(output int counted);
    int kind;
    int junk;
    int cut;
    build_q.delete();
    junk = 0;
    kind = $urandom_range(99);
    if (kind < 85) begin
      build_good_body(junk);
      // Early end of the body somewhere inside.
      if (kind >= 70) begin
        cut = $urandom_range(0, build_q.size() - 1);
        while (build_q.size() > cut + 1) void'(build_q.pop_back());
        junk = 0;
      end
    end else if (kind < 93) begin
      build_bad_size_body();
    end else begin
      repeat ($urandom_range(1, 8)) push_raw(8'($urandom));
    end
    build_q[build_q.size() - 1].last = 1'b1;
    counted = build_q.size() - junk;
    foreach (build_q[i]) body_q.push_back(build_q[i]);
    bodies_sent++;
  endtask

  initial begin
    logic [31:0] limit_val;
    int          phase_items;
    int          counted;
    directed_rows = '{
      // Chunk with an extension, then the body stops after the data separator.
      '{8'h31, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_SEMI, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_LF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h5A, 1'b0, 1'b1, 8'h5A, 1'b1, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_CR, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_LF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_TRUNC},
      // Empty size field ends the stream.
      '{cbd_pkg::CHAR_LF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_OK},
      // Non-hex byte in the size field, later bytes ignored.
      '{8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_BAD},
      // One above the reset size limit.
      '{8'h31, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h31, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_BAD},
      // Body ends in the middle of the data.
      '{8'h32, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_CR, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{cbd_pkg::CHAR_LF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, cbd_pkg::ST_OK},
      '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, cbd_pkg::ST_OVER},
      // Body ends inside a nonzero size field, then inside a zero one.
      '{8'h46, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_OVER},
      '{8'h30, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, cbd_pkg::ST_OK}
    };

    send_gap_pct = 14;
    ready_drop_pct = 66;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) body_q.push_back(directed_rows[i]);
    bytes_sent += $size(directed_rows);
    bodies_sent += 7;
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: limit_val = 32'd16;
        1: limit_val = 32'hFFFF_FFFF;
        2: limit_val = $urandom_range(17, 300);
        3: limit_val = cbd_pkg::MAX_CHUNK_RESET;
        default: begin
          limit_val = $urandom;
          if (limit_val < 16) limit_val = 16;
        end
      endcase
      if (p == 2) begin
        send_gap_pct = 66;
        ready_drop_pct = 14;
      end else if (p == 4) begin
        send_gap_pct = 0;
        ready_drop_pct = 0;
      end
      set_max_chunk(limit_val);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        queue_random_body(counted);
        phase_items += counted;
      end
      bytes_sent += phase_items;
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d expected output transfers never arrived", decoded_q.size());
      errors++;
    end
    $display("Run covered %0d bodies with %0d body bytes, at the reset size limit and six written ones.",
             bodies_sent, bytes_sent);
    $display("Checked %0d output transfers, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> chunked_body_decoder.f
rtl/cbd_pkg.sv
rtl/cbd_in_stage.sv
rtl/cbd_parser.sv
rtl/chunked_body_decoder.sv
tb/chunked_body_decoder_test.sv
